@@ sv/akd_pkg.sv @@
// Shared constants, request types and configuration types of the ADC ladder key decoder.
package akd_pkg;

    localparam int NUM_KEYS     = 6;
    localparam int FIFO_DEPTH   = 16;
    localparam int NUM_CHANNELS = 2;

    localparam int LEVEL_W  = 10;
    localparam int CODE_W   = 8;
    localparam int WIN_W    = 9;
    localparam int SUM_W    = 14;
    localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W    = LEVEL_W + 1;
    localparam int LEVELS_W = 60;
    localparam int CODES_W  = 48;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEVEL_W-1:0] FULL_SCALE   = 10'h3ff;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 9'd40;

    localparam logic [IDX_W-1:0] REG_KEY_LEVELS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CODES_FIRST = 3'd1;
    localparam logic [IDX_W-1:0] REG_CODES_SECOND = 3'd2;
    localparam logic [IDX_W-1:0] REG_NO_KEY_CODE = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW      = 3'd4;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    typedef struct packed {
        logic               channel;
        logic [LEVEL_W-1:0] sample;
        logic               last_sample;
    } sample_req_t;

    typedef struct packed {
        logic               out_channel;
        logic               event_kind;
        logic [CODE_W-1:0]  event_code;
        logic [LEVEL_W-1:0] average_level;
    } key_event_t;

    // One closed burst, handed from the front end to the back end.
    typedef struct packed {
        logic             channel;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } burst_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] key_levels;
        logic [CODES_W-1:0]  codes_first_channel;
        logic [CODES_W-1:0]  codes_second_channel;
        logic [CODE_W-1:0]   no_key_code;
        logic [WIN_W-1:0]    window_half_width;
    } akd_cfg_t;

endpackage

@@ sv/adc_ladder_key_decoder.sv @@
// Top level of the ADC ladder key decoder: configuration registers, front end, queue, back end.
// A closing sample gives its key event after it passes the queue, 14 divide steps of one
// quotient bit each and the classify state that loads the output register.
// Throughput: one sample per cycle while the queue has room; a closed burst occupies the
// back-end divider, and a two-entry queue lets the front end keep taking samples meanwhile.
// Reset (rst_n, asynchronous, active low) clears the burst, the queue, the held keys and
// the output; configuration returns to zero with a key window of 40 counts.
module adc_ladder_key_decoder
    import akd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_req_t       sample_req,
    output logic              event_valid,
    input  logic              event_ready,
    output key_event_t        event_data
);

    // Registers sit at 8-byte spacing because the key level register is 60 bits wide.
    akd_cfg_t          cfg_reg;
    logic              cfg_write;
    logic [IDX_W-1:0]  reg_idx;

    logic   push_valid;
    logic   push_ready;
    burst_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    burst_t pop_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    // A write must only be issued while the decoder is idle, so that the back end sees a
    // stable configuration for every burst it handles; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_levels           <= '0;
            cfg_reg.codes_first_channel  <= '0;
            cfg_reg.codes_second_channel <= '0;
            cfg_reg.no_key_code          <= '0;
            cfg_reg.window_half_width    <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_KEY_LEVELS:   cfg_reg.key_levels           <= pwdata[LEVELS_W-1:0];
                REG_CODES_FIRST:  cfg_reg.codes_first_channel  <= pwdata[CODES_W-1:0];
                REG_CODES_SECOND: cfg_reg.codes_second_channel <= pwdata[CODES_W-1:0];
                REG_NO_KEY_CODE:  cfg_reg.no_key_code          <= pwdata[CODE_W-1:0];
                REG_WINDOW:       cfg_reg.window_half_width    <= pwdata[WIN_W-1:0];
                default:          cfg_reg.no_key_code          <= cfg_reg.no_key_code;
            endcase
        end
    end

    // Read-back of the register selected by paddr; unused addresses read zero.
    always_comb
    begin
        case (reg_idx)
            REG_KEY_LEVELS:   prdata = DATA_W'(cfg_reg.key_levels);
            REG_CODES_FIRST:  prdata = DATA_W'(cfg_reg.codes_first_channel);
            REG_CODES_SECOND: prdata = DATA_W'(cfg_reg.codes_second_channel);
            REG_NO_KEY_CODE:  prdata = DATA_W'(cfg_reg.no_key_code);
            REG_WINDOW:       prdata = DATA_W'(cfg_reg.window_half_width);
            default:          prdata = '0;
        endcase
    end

    // The front end sums each burst and hands it over on its last sample.
    akd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_req   (sample_req),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // Closed bursts wait here while the divider works on an earlier one.
    akd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back end averages, classifies and emits press and release events.
    akd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_data  (event_data)
    );

endmodule

@@ sv/akd_front.sv @@
// Front end: accumulates ADC samples of a burst and closes the burst on its last sample.
module akd_front
    import akd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_req_t sample_req,
    output logic        push_valid,
    input  logic        push_ready,
    output burst_t      push_data
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             burst_full;
    logic             accept;

    assign sample_ready = push_ready;
    assign accept       = sample_valid && sample_ready;
    assign burst_full   = (count_reg == CNT_W'(FIFO_DEPTH));

    // Samples past the FIFO depth are not added.
    always_comb
    begin
        if (burst_full)
        begin
            sum_next   = sum_reg;
            count_next = count_reg;
        end
        else
        begin
            sum_next   = sum_reg + SUM_W'(sample_req.sample);
            count_next = count_reg + CNT_W'(1);
        end
    end

    // A burst closed on a channel that does not exist is dropped here.
    assign push_valid = accept && sample_req.last_sample
                        && (int'(sample_req.channel) < NUM_CHANNELS);
    assign push_data  = '{channel: sample_req.channel, sum: sum_next, count: count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (sample_req.last_sample)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

@@ sv/akd_queue.sv @@
// Short queue of closed bursts between the front end and the back end.
module akd_queue
    import akd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  burst_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output burst_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    burst_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

@@ sv/akd_back.sv @@
// Back end: divides a burst into its average, classifies it and tracks the held key per channel.
module akd_back
    import akd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  akd_cfg_t   cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  burst_t     pop_data,
    output logic       event_valid,
    input  logic       event_ready,
    output key_event_t event_data
);

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EVAL = 3'b100
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    burst_t            job_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              held_valid_reg [NUM_CHANNELS];
    logic [CODE_W-1:0] held_code_reg [NUM_CHANNELS];
    logic              out_valid_reg;
    key_event_t        out_reg;

    logic [CNT_W:0]     shifted;
    logic               quo_bit;
    logic [CNT_W-1:0]   rem_next;
    logic [LEVEL_W-1:0] avg;
    logic [CMP_W-1:0]   avg_e;
    logic [CMP_W-1:0]   avg_w;
    logic [CMP_W-1:0]   top;
    logic [CMP_W-1:0]   lvl;
    logic [CODES_W-1:0] code_table;
    logic [CODE_W-1:0]  code;
    logic               is_release;
    logic               is_press;
    logic               cur_valid;
    logic [CODE_W-1:0]  chan_held_code;
    logic               emit_release;
    logic               emit_press;
    logic               out_free;
    logic               finish;
    logic               load_out;

    assign pop_ready   = (state_reg == ST_IDLE);
    assign event_valid = out_valid_reg;
    assign event_data  = out_reg;

    // One quotient bit per cycle: restoring division of the sum by the count.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        quo_bit = (shifted >= {1'b0, job_reg.count});
        if (quo_bit)
        begin
            rem_next = CNT_W'(shifted - {1'b0, job_reg.count});
        end
        else
        begin
            rem_next = shifted[CNT_W-1:0];
        end
    end

    // Classification of the finished average; signed window bounds are
    // compared as avg + w >= level to stay unsigned.
    always_comb
    begin
        avg        = quo_reg[LEVEL_W-1:0];
        avg_e      = {1'b0, avg};
        avg_w      = avg_e + CMP_W'(cfg.window_half_width);
        top        = {1'b0, cfg.key_levels[LEVEL_W*(NUM_KEYS-1) +: LEVEL_W]}
                     + CMP_W'(cfg.window_half_width);
        is_release = (avg_e > top) && (avg != FULL_SCALE);
        is_press   = (avg_w >= {1'b0, cfg.key_levels[0 +: LEVEL_W]}) && (avg_e <= top);
        code_table = job_reg.channel ? cfg.codes_second_channel : cfg.codes_first_channel;
        code       = cfg.no_key_code;
        lvl        = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            lvl = {1'b0, cfg.key_levels[LEVEL_W*k +: LEVEL_W]};
            if ((avg_w >= lvl) && (avg_e <= lvl + CMP_W'(cfg.window_half_width)))
            begin
                code = code_table[CODE_W*k +: CODE_W];
            end
        end
        cur_valid      = held_valid_reg[job_reg.channel];
        chan_held_code = held_code_reg[job_reg.channel];
        emit_release   = is_release && cur_valid;
        emit_press     = is_press && !(cur_valid && (chan_held_code == code));
        out_free       = !out_valid_reg || event_ready;
        finish         = (state_reg == ST_EVAL) && out_free;
        load_out       = finish && (emit_release || emit_press);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && (pop_data.count != '0))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                held_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (event_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (finish && emit_release)
            begin
                held_valid_reg[job_reg.channel] <= 1'b0;
            end
            else if (finish && emit_press)
            begin
                held_valid_reg[job_reg.channel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            job_reg  <= pop_data;
            quo_reg  <= pop_data.sum;
            rem_reg  <= '0;
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg  <= rem_next;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (finish && emit_press)
        begin
            held_code_reg[job_reg.channel] <= code;
        end
        if (load_out)
        begin
            out_reg.out_channel   <= job_reg.channel;
            out_reg.event_kind    <= emit_release ? EV_RELEASE : EV_PRESS;
            out_reg.event_code    <= emit_release ? chan_held_code : code;
            out_reg.average_level <= avg;
        end
    end

    a_burst_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |-> (pop_data.count != '0
                                      && pop_data.count <= CNT_W'(FIFO_DEPTH)))
        else $error("closed burst with an impossible sample count");

    a_press_updates_held: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_press) |=> (held_valid_reg[job_reg.channel]
                                      && held_code_reg[job_reg.channel] == event_data.event_code
                                      && event_data.event_kind == EV_PRESS))
        else $error("press event does not match the held key");

    a_release_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_release) |=> (!held_valid_reg[job_reg.channel] && event_valid
                                        && event_data.event_kind == EV_RELEASE))
        else $error("release event left the key held");

    a_eval_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && out_valid_reg && !event_ready) |=> (state_reg == ST_EVAL))
        else $error("result finished while the output register was still occupied");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the ADC ladder key decoder: sample requests in, key events out.
module tb
    import akd_pkg::*;
;

    localparam int RESET_CYCLES    = 8;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 240;
    localparam int PRESSURE_PHASE  = 5;
    localparam int QUIET_PHASE     = NUM_PHASES - 1;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;
    localparam int CYCLE_LIMIT     = 500000;

    // Keeps its own copy of the decoder state and registers, predicts the key
    // events that the accepted sample requests give and checks the events that come out.
    class key_event_board;
        logic [LEVELS_W-1:0] key_levels;
        logic [CODES_W-1:0]  key_codes [NUM_CHANNELS];
        logic [CODE_W-1:0]   no_key_code;
        logic [WIN_W-1:0]    window_half_width;
        logic [SUM_W-1:0]    burst_sum;
        logic [CNT_W-1:0]    burst_count;
        logic                held_valid [NUM_CHANNELS];
        logic [CODE_W-1:0]   held_code [NUM_CHANNELS];
        key_event_t          expected_events [$];
        int                  errors;

        function new();
            key_levels        = '0;
            no_key_code       = '0;
            window_half_width = WINDOW_RESET;
            burst_sum         = '0;
            burst_count       = '0;
            errors            = 0;
            foreach (key_codes[c])
            begin
                key_codes[c]  = '0;
                held_valid[c] = 1'b0;
                held_code[c]  = '0;
            end
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_KEY_LEVELS:   key_levels = value[LEVELS_W-1:0];
                REG_CODES_FIRST:  key_codes[0] = value[CODES_W-1:0];
                REG_CODES_SECOND: key_codes[1] = value[CODES_W-1:0];
                REG_NO_KEY_CODE:  no_key_code = value[CODE_W-1:0];
                REG_WINDOW:       window_half_width = value[WIN_W-1:0];
                default:          ;
            endcase
        endfunction

        function int level_at(int k);
            return int'(key_levels[LEVEL_W*k +: LEVEL_W]);
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_request(sample_req_t req);
            int          count;
            int          avg;
            int          w;
            int          top;
            int          bottom;
            int          lv;
            logic [CODE_W-1:0] code;
            key_event_t  ev;
            if (burst_count < FIFO_DEPTH)
            begin
                burst_sum   = burst_sum + req.sample;
                burst_count = burst_count + 1'b1;
            end
            if (!req.last_sample)
                return;
            count       = int'(burst_count);
            avg         = (count != 0) ? int'(burst_sum) / count : 0;
            burst_sum   = '0;
            burst_count = '0;
            if (count == 0 || int'(req.channel) >= NUM_CHANNELS)
                return;
            w      = int'(window_half_width);
            top    = level_at(NUM_KEYS - 1) + w;
            bottom = level_at(0) - w;
            ev.out_channel   = req.channel;
            ev.average_level = avg[LEVEL_W-1:0];
            if (avg > top && avg < int'(FULL_SCALE))
            begin
                if (!held_valid[req.channel])
                    return;
                ev.event_kind = EV_RELEASE;
                ev.event_code = held_code[req.channel];
                held_valid[req.channel] = 1'b0;
                expected_events.push_back(ev);
            end
            else if (avg >= bottom && avg <= top)
            begin
                // The highest key whose window holds the average wins.
                code = no_key_code;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    lv = level_at(k);
                    if (avg >= lv - w && avg <= lv + w)
                        code = key_codes[req.channel][CODE_W*k +: CODE_W];
                end
                if (held_valid[req.channel] && held_code[req.channel] == code)
                    return;
                held_valid[req.channel] = 1'b1;
                held_code[req.channel]  = code;
                ev.event_kind = EV_PRESS;
                ev.event_code = code;
                expected_events.push_back(ev);
            end
        endfunction

        function void check_event(key_event_t got);
            key_event_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected key event: channel %0d kind %0d code %0h level %0d",
                       got.out_channel, got.event_kind, got.event_code, got.average_level);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got.out_channel !== want.out_channel)
            begin
                $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
                errors++;
            end
            if (got.event_kind !== want.event_kind)
            begin
                $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
                errors++;
            end
            if (got.event_code !== want.event_code)
            begin
                $error("event_code: expected %0h, got %0h", want.event_code, got.event_code);
                errors++;
            end
            if (got.average_level !== want.average_level)
            begin
                $error("average_level: expected %0d, got %0d",
                       want.average_level, got.average_level);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    sample_req_t       sample_req = '0;
    logic              event_valid;
    logic              event_ready = 1'b0;
    key_event_t        event_data;

    key_event_board    sb;
    int                items_sent = 0;
    int unsigned       cycle_count = 0;
    bit                sender_idling = 1'b0;
    bit                receiver_idling = 1'b0;
    bit                start_hold_off = 1'b0;

    adc_ladder_key_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_req   (sample_req),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .event_data   (event_data)
    );

    always #10 clk = ~clk;

    // All handshakes are observed at the rising edge, before the block updates.
    // Every accepted sample request feeds the predictor, every accepted key
    // event is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                sb.note_request(sample_req);
            if (event_valid && event_ready)
                sb.check_event(event_data);
        end
    end

    // The event side. Ready is driven at the falling edge. It drops in random
    // bursts while idling is on, and once it holds off for a long stretch so
    // that the queue inside the block fills up and the sample side stalls.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (start_hold_off)
            begin
                start_hold_off = 1'b0;
                event_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else if (receiver_idling && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 19);
                event_ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                event_ready = 1'b1;
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [LEVEL_W-1:0] clamp_level(int v);
        if (v < 0)
            return '0;
        if (v > int'(FULL_SCALE))
            return FULL_SCALE;
        return v[LEVEL_W-1:0];
    endfunction

    // Register write in a setup phase, then an access phase. pready is always high,
    // so the write lands at the first rising edge of the access phase.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_settings(input logic [LEVELS_W-1:0] levels,
                                  input logic [CODES_W-1:0] first_codes,
                                  input logic [CODES_W-1:0] second_codes,
                                  input logic [CODE_W-1:0] fallback,
                                  input logic [WIN_W-1:0] window);
        write_register(REG_KEY_LEVELS, DATA_W'(levels));
        write_register(REG_CODES_FIRST, DATA_W'(first_codes));
        write_register(REG_CODES_SECOND, DATA_W'(second_codes));
        write_register(REG_NO_KEY_CODE, DATA_W'(fallback));
        write_register(REG_WINDOW, DATA_W'(window));
    endtask

    // Offers one sample request and returns at the edge where it is taken.
    // Valid stays high into the next request unless a random gap follows.
    task automatic send_sample(input logic ch, input logic [LEVEL_W-1:0] value,
                               input logic last);
        sample_req_t req;
        int          gap;
        req.channel     = ch;
        req.sample      = value;
        req.last_sample = last;
        @(negedge clk);
        sample_valid = 1'b1;
        sample_req   = req;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        items_sent++;
        if (sender_idling && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drops valid, waits for every predicted event, then lets any burst that
    // gives no event leave the divider before registers are touched again.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One burst aimed at a region of interest: inside a key window, anywhere,
    // the release band above the top window, full scale, or pure noise with
    // stray closing marks. Most bursts are short; a few overflow the FIFO.
    task automatic send_random_burst();
        int   kind;
        int   len;
        int   target;
        int   spread;
        int   w;
        int   top;
        int   v;
        int   i;
        logic ch;
        logic ch_i;
        logic last;
        w      = int'(sb.window_half_width);
        top    = sb.level_at(NUM_KEYS - 1) + w;
        ch     = 1'($urandom_range(0, 1));
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 4)
                                             : $urandom_range(1, 5);
        kind   = $urandom_range(0, 99);
        spread = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
        if (kind < 55)
        begin
            target = sb.level_at($urandom_range(0, NUM_KEYS - 1))
                   + int'($urandom_range(0, 2 * w)) - w;
        end
        else if (kind < 70)
        begin
            target = $urandom_range(0, 1023);
            spread = $urandom_range(0, 40);
        end
        else if (kind < 85)
        begin
            target = (top < 1022) ? int'($urandom_range(top + 1, 1022))
                                  : int'($urandom_range(0, 1023));
        end
        else if (kind < 90)
        begin
            target = int'(FULL_SCALE);
            spread = 0;
        end
        else
        begin
            target = -1;
        end
        for (i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            if (target < 0)
            begin
                v    = $urandom_range(0, 1023);
                ch_i = 1'($urandom_range(0, 1));
                last = last || ($urandom_range(0, 3) == 0);
            end
            else
            begin
                v    = target + int'($urandom_range(0, 2 * spread)) - spread;
                ch_i = (last || $urandom_range(0, 9) != 0) ? ch : ~ch;
            end
            send_sample(ch_i, clamp_level(v), last);
        end
    endtask

    // Register settings of one random phase. Levels are mostly ascending;
    // some phases pin the extremes of the level range, of the window and of
    // the codes, and one phase scrambles the level order.
    task automatic apply_phase_settings(input int phase);
        logic [LEVELS_W-1:0] levels;
        logic [CODES_W-1:0]  first_codes;
        logic [CODES_W-1:0]  second_codes;
        logic [CODE_W-1:0]   fallback;
        logic [WIN_W-1:0]    window;
        int                  cur;
        int                  k;
        cur = $urandom_range(0, 150);
        for (k = 0; k < NUM_KEYS; k++)
        begin
            levels[LEVEL_W*k +: LEVEL_W] = clamp_level(cur);
            cur += $urandom_range(30, 180);
        end
        first_codes  = CODES_W'({$urandom, $urandom});
        second_codes = CODES_W'({$urandom, $urandom});
        fallback     = CODE_W'($urandom_range(0, 255));
        window       = WIN_W'($urandom_range(5, 60));
        case (phase)
            0:
            begin
                window   = '0;
                fallback = '1;
            end
            1:
            begin
                levels[0 +: LEVEL_W] = '0;
                levels[LEVEL_W*(NUM_KEYS-1) +: LEVEL_W] = FULL_SCALE;
                window = '1;
            end
            3:
            begin
                levels = LEVELS_W'({$urandom, $urandom});
                window = WIN_W'($urandom_range(0, 100));
            end
            4:
            begin
                first_codes  = '1;
                second_codes = '1;
                fallback     = '0;
                window       = WINDOW_RESET;
            end
            6:
            begin
                levels[0 +: LEVEL_W] = '0;
                levels[LEVEL_W*(NUM_KEYS-1) +: LEVEL_W] = FULL_SCALE;
                window = WIN_W'($urandom_range(0, 200));
            end
            default: ;
        endcase
        write_settings(levels, first_codes, second_codes, fallback, window);
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int i;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset settings: every level is zero with a 40-count window, so a
        // zero average matches all six keys and the top one wins.
        send_sample(1'b0, 10'd0, 1'b1);
        send_sample(1'b0, 10'd500, 1'b1);
        wait_idle();

        // Directed settings: keys at 100..850 in steps of 150, window 40.
        write_settings({10'd850, 10'd700, 10'd550, 10'd400, 10'd250, 10'd100},
                       48'h16_15_14_13_12_11, 48'h26_25_24_23_22_21, 8'hee, 9'd40);
        send_sample(1'b0, 10'd60, 1'b1);     // lower edge of the bottom window
        send_sample(1'b0, 10'd140, 1'b1);    // same key again, no event
        send_sample(1'b0, 10'd141, 1'b1);    // between windows gives the no-key code
        send_sample(1'b1, 10'd890, 1'b1);    // upper edge of the top window
        send_sample(1'b1, 10'd891, 1'b1);    // just above it is a release
        send_sample(1'b1, 10'd891, 1'b1);    // release with nothing held
        send_sample(1'b0, 10'd1023, 1'b1);   // full scale is never a release
        send_sample(1'b0, 10'd59, 1'b1);     // below the bottom window is dropped
        // A full burst across both channels: the closing sample is not summed
        // and its channel owns the burst.
        for (i = 0; i < FIFO_DEPTH; i++)
            send_sample(1'(i), 10'd400, 1'b0);
        send_sample(1'b1, 10'd1023, 1'b1);
        send_sample(1'b0, 10'd1022, 1'b1);   // top of the release band

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            apply_phase_settings(phase);
            sender_idling   = (phase != QUIET_PHASE) && ($urandom_range(0, 3) != 0);
            receiver_idling = (phase != QUIET_PHASE) && ($urandom_range(0, 3) != 0);
            if (phase == PRESSURE_PHASE)
                start_hold_off = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_burst();
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
